[rtl/sfac_pkg.sv]
// ----------------------------------------------------------------------------
// sfac_pkg
// shared types, constants and single-precision helper functions for the
// sphere frame anomaly check pipeline
// ----------------------------------------------------------------------------
package sfac_pkg;

   localparam int FW = 32;
   localparam int IW = 16;
   localparam int UW = 50;
   localparam int SQ_STEPS     = 24;
   localparam int SQ_PER_STAGE = 2;
   localparam int SQ_STAGES    = SQ_STEPS / SQ_PER_STAGE;

   localparam logic [2:0] ANOM_NONE = 3'd0;
   localparam logic [2:0] ANOM_BAD  = 3'd1;
   localparam logic [2:0] ANOM_ZERO = 3'd2;
   localparam logic [2:0] ANOM_POS  = 3'd3;
   localparam logic [2:0] ANOM_RAD  = 3'd4;

   localparam logic CSR_POS_THR = 1'b0;
   localparam logic CSR_RAD_THR = 1'b1;

   localparam logic [FW-1:0] THR_RESET = 32'h40A0_0000;
   localparam logic [FW-1:0] QNAN      = 32'h7FC0_0000;
   localparam logic [FW-1:0] INF_MAG   = 32'h7F80_0000;

   typedef struct packed {
      logic [FW-1:0] prev_x;
      logic [FW-1:0] prev_y;
      logic [FW-1:0] prev_z;
      logic [FW-1:0] prev_radius;
      logic [FW-1:0] cur_x;
      logic [FW-1:0] cur_y;
      logic [FW-1:0] cur_z;
      logic [FW-1:0] cur_radius;
      logic          has_prev;
      logic [IW-1:0] element_index;
   } req_type;

   typedef struct packed {
      logic [2:0]    anomaly;
      logic [IW-1:0] result_index;
   } rsp_type;

   // flags and pass-through data that ride along with the arithmetic
   typedef struct packed {
      logic          has_prev;
      logic          bad;
      logic          zero_hit;
      logic [IW-1:0] index;
      logic [FW-1:0] rd;
   } meta_type;

   // unrounded result: value = um * 2^(ue - 149)
   typedef struct packed {
      logic                 special;
      logic [FW-1:0]        spec_bits;
      logic                 sign;
      logic signed [11:0]   ue;
      logic [UW-1:0]        um;
   } unr_type;

   // square root recurrence state
   typedef struct packed {
      logic               special;
      logic [FW-1:0]      spec_bits;
      logic signed [9:0]  e;
      logic [48:0]        rem;
      logic [48:0]        q;
   } sq_type;

   function automatic logic is_nan(input logic [FW-1:0] x);
      return (&x[30:23]) && (|x[22:0]);
   endfunction

   function automatic logic is_inf(input logic [FW-1:0] x);
      return (&x[30:23]) && !(|x[22:0]);
   endfunction

   function automatic logic is_bad(input logic [FW-1:0] x);
      return &x[30:23];
   endfunction

   function automatic logic is_zero(input logic [FW-1:0] x);
      return x[30:0] == 31'd0;
   endfunction

   // ieee greater-than, false when either side is nan
   function automatic logic float_gt(input logic [FW-1:0] a, input logic [FW-1:0] b);
      logic [FW-1:0] ka;
      logic [FW-1:0] kb;
      ka = a[31] ? ~a : {1'b1, a[30:0]};
      kb = b[31] ? ~b : {1'b1, b[30:0]};
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (is_zero(a) && is_zero(b)) return 1'b0;
      return ka > kb;
   endfunction

   // alignment and add of a + b, three guard bits, the lowest of them sticky
   function automatic unr_type fadd_pre(input logic [FW-1:0] a, input logic [FW-1:0] b);
      unr_type     r;
      logic        sa, sb, sbig, ssm;
      logic [7:0]  ea, eb, ebig, esm, d;
      logic [23:0] ma, mb, mbig, msm;
      logic [26:0] xb, xs, xsh, lost;
      logic [27:0] mag;
      r  = '0;
      sa = a[31];
      sb = b[31];
      ea = (a[30:23] == 8'd0) ? 8'd0 : a[30:23] - 8'd1;
      eb = (b[30:23] == 8'd0) ? 8'd0 : b[30:23] - 8'd1;
      ma = {|a[30:23], a[22:0]};
      mb = {|b[30:23], b[22:0]};
      if ({eb, mb} > {ea, ma}) begin
         sbig = sb; ebig = eb; mbig = mb;
         ssm  = sa; esm  = ea; msm  = ma;
      end else begin
         sbig = sa; ebig = ea; mbig = ma;
         ssm  = sb; esm  = eb; msm  = mb;
      end
      d  = ebig - esm;
      xb = {mbig, 3'b000};
      xs = {msm, 3'b000};
      if (d >= 8'd27) begin
         xsh  = 27'd0;
         lost = {26'd0, |msm};
      end else begin
         xsh  = xs >> d;
         lost = xs << (8'd27 - d);
      end
      xsh[0] = xsh[0] | (lost != 27'd0);
      if (sbig == ssm) mag = {1'b0, xb} + {1'b0, xsh};
      else mag = {1'b0, xb} - {1'b0, xsh};
      r.sign = (mag == 28'd0) ? (sa & sb) : sbig;
      r.ue   = $signed({4'd0, ebig}) - 12'sd3;
      r.um   = UW'(mag);
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (sa != sb))) begin
         r.special   = 1'b1;
         r.spec_bits = QNAN;
      end else if (is_inf(a)) begin
         r.special   = 1'b1;
         r.spec_bits = a;
      end else if (is_inf(b)) begin
         r.special   = 1'b1;
         r.spec_bits = b;
      end
      return r;
   endfunction

   // mantissa product of a * b
   function automatic unr_type fmul_pre(input logic [FW-1:0] a, input logic [FW-1:0] b);
      unr_type     r;
      logic [7:0]  ea, eb;
      logic [23:0] ma, mb;
      r  = '0;
      ea = (a[30:23] == 8'd0) ? 8'd0 : a[30:23] - 8'd1;
      eb = (b[30:23] == 8'd0) ? 8'd0 : b[30:23] - 8'd1;
      ma = {|a[30:23], a[22:0]};
      mb = {|b[30:23], b[22:0]};
      r.sign = a[31] ^ b[31];
      r.ue   = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd149;
      r.um   = {26'd0, ma} * {26'd0, mb};
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
      begin
         r.special   = 1'b1;
         r.spec_bits = QNAN;
      end else if (is_inf(a) || is_inf(b)) begin
         r.special   = 1'b1;
         r.spec_bits = {a[31] ^ b[31], INF_MAG[30:0]};
      end
      return r;
   endfunction

   // normalize and round to nearest even, with subnormals and overflow
   function automatic logic [FW-1:0] round_pack(input unr_type u);
      logic [5:0]         p;
      logic signed [13:0] p_s, ue_s, ebias, sh, base;
      logic [UW-1:0]      q_w, tmp;
      logic               rbit, st, inc;
      logic [40:0]        pk;
      p = 6'd0;
      for (int i = 0; i < UW; i++) begin
         if (u.um[i]) p = 6'(i);
      end
      p_s   = $signed({8'd0, p});
      ue_s  = $signed({{2{u.ue[11]}}, u.ue});
      ebias = p_s + ue_s - 14'sd22;
      sh    = p_s - 14'sd23;
      if (sh < -ue_s) sh = -ue_s;
      if (sh > 14'sd51) sh = 14'sd51;
      if (sh <= 14'sd0) begin
         q_w  = u.um << (-sh);
         rbit = 1'b0;
         st   = 1'b0;
      end else begin
         q_w  = u.um >> sh;
         tmp  = u.um >> (sh - 14'sd1);
         rbit = tmp[0];
         st   = |(u.um & ((UW'(1) << (sh - 14'sd1)) - UW'(1)));
      end
      inc  = rbit & (st | q_w[0]);
      base = (ebias >= 14'sd1) ? ebias - 14'sd1 : 14'sd0;
      pk   = (41'(base[12:0]) << 23) + 41'(q_w[23:0]) + 41'(inc);
      if (u.special) return u.spec_bits;
      if (u.um == '0) return {u.sign, 31'd0};
      if (pk >= 41'(INF_MAG)) return {u.sign, INF_MAG[30:0]};
      return {u.sign, pk[30:0]};
   endfunction

   // operand preparation for the bit-pair square root
   function automatic sq_type sqrt_pre(input logic [FW-1:0] s);
      sq_type            r;
      logic [4:0]        p;
      logic [23:0]       m;
      logic [24:0]       m2;
      logic signed [9:0] e;
      r = '0;
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (s[i]) p = 5'(i);
      end
      if (s[30:23] == 8'd0) begin
         m = {1'b0, s[22:0]} << (5'd23 - p);
         e = $signed({5'd0, p}) - 10'sd149;
      end else begin
         m = {1'b1, s[22:0]};
         e = $signed({2'd0, s[30:23]}) - 10'sd127;
      end
      if (e[0]) begin
         m2 = {m, 1'b0};
         e  = e - 10'sd1;
      end else begin
         m2 = {1'b0, m};
      end
      r.rem = 49'(m2) << 23;
      r.q   = 49'd0;
      r.e   = e >>> 1;
      if (is_zero(s) || is_nan(s) || (is_inf(s) && !s[31])) begin
         r.special   = 1'b1;
         r.spec_bits = s;
      end else if (s[31]) begin
         r.special   = 1'b1;
         r.spec_bits = QNAN;
      end
      return r;
   endfunction

   // one result bit of the square root
   function automatic sq_type sqrt_step(input sq_type s, input int k);
      sq_type      r;
      logic [48:0] bitv, t;
      r    = s;
      bitv = 49'd1 << (46 - 2 * k);
      t    = s.q + bitv;
      if (s.rem >= t) begin
         r.rem = s.rem - t;
         r.q   = (s.q >> 1) + bitv;
      end else begin
         r.q = s.q >> 1;
      end
      return r;
   endfunction

   function automatic logic [FW-1:0] sqrt_post(input sq_type s);
      logic [48:0]       q;
      logic signed [9:0] e;
      q = s.q + 49'(s.rem > s.q);
      e = s.e;
      if (q[24]) begin
         q = q >> 1;
         e = e + 10'sd1;
      end
      e = e + 10'sd127;
      if (s.special) return s.spec_bits;
      return {1'b0, e[7:0], q[22:0]};
   endfunction

endpackage

[rtl/sphere_frame_anomaly_check_top.sv]
// ----------------------------------------------------------------------------
// sphere_frame_anomaly_check_top
// flags nan/inf, collapsed radius, position jumps and radius jumps between
// two frames of one bounding sphere
// ----------------------------------------------------------------------------
// an accepted transfer passes the front stages, the square root stages and the output register before rsp_valid
// throughput: one transfer per cycle; the whole pipeline holds while a
//   result waits under rsp_stall, set by the single shared stage enable
// reset: clears all stage valid bits, thresholds return to 5.0
module sphere_frame_anomaly_check_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfac_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfac_pkg::rsp_type rsp_payload,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import sfac_pkg::*;

   logic [FW-1:0] pos_thr_ff, rad_thr_ff;
   logic          en;
   logic          fr_valid, sq_valid;
   meta_type      fr_meta, sq_meta;
   logic [FW-1:0] fr_sum, sq_root;
   logic [2:0]    code;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_thr_ff <= THR_RESET;
         rad_thr_ff <= THR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POS_THR: pos_thr_ff <= csr_wdata;
            CSR_RAD_THR: rad_thr_ff <= csr_wdata;
            default:     pos_thr_ff <= pos_thr_ff;
         endcase
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   sfac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .out_valid (fr_valid),
      .out_meta  (fr_meta),
      .out_sum   (fr_sum)
   );

   sfac_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_meta   (fr_meta),
      .in_val    (fr_sum),
      .out_valid (sq_valid),
      .out_meta  (sq_meta),
      .out_root  (sq_root)
   );

   // priority order of the checks
   always_comb begin
      code = ANOM_NONE;
      if (sq_meta.bad) code = ANOM_BAD;
      else if (sq_meta.has_prev) begin
         if (sq_meta.zero_hit) code = ANOM_ZERO;
         else if (float_gt(sq_root, pos_thr_ff)) code = ANOM_POS;
         else if (float_gt({1'b0, sq_meta.rd[30:0]}, rad_thr_ff)) code = ANOM_RAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.anomaly      <= code;
         rsp_ff.result_index <= sq_meta.index;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/sfac_front.sv]
// ----------------------------------------------------------------------------
// sfac_front
// differences, squares and sum of squares, eight register stages
// ----------------------------------------------------------------------------
module sfac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  sfac_pkg::req_type  in_data,
   output logic               out_valid,
   output sfac_pkg::meta_type out_meta,
   output logic [31:0]        out_sum
);
   import sfac_pkg::*;

   logic [7:0] valid_ff, valid_in;
   meta_type   meta_ff [0:7];
   meta_type   meta_in [0:7];

   unr_type       dx_u_ff, dy_u_ff, dz_u_ff, rd_u_ff;
   logic [FW-1:0] dx_ff, dy_ff, dz_ff;
   unr_type       sx_u_ff, sy_u_ff, sz_u_ff;
   logic [FW-1:0] sx_ff, sy_ff, sz_ff, sz5_ff;
   unr_type       sxy_u_ff;
   logic [FW-1:0] sxy_ff, sz6_ff;
   unr_type       sum_u_ff;
   logic [FW-1:0] sum_ff;

   always_comb begin
      valid_in = {valid_ff[6:0], in_valid};
      meta_in[0].has_prev = in_data.has_prev;
      meta_in[0].bad      = is_bad(in_data.cur_x) | is_bad(in_data.cur_y) |
                            is_bad(in_data.cur_z) | is_bad(in_data.cur_radius);
      meta_in[0].zero_hit = is_zero(in_data.cur_radius) & !is_zero(in_data.prev_radius);
      meta_in[0].index    = in_data.element_index;
      meta_in[0].rd       = '0;
      meta_in[1]          = meta_ff[0];
      meta_in[1].rd       = round_pack(rd_u_ff);
      for (int i = 2; i < 8; i++) begin
         meta_in[i] = meta_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            meta_ff[i] <= meta_in[i];
         end
         dx_u_ff  <= fadd_pre(in_data.cur_x, {~in_data.prev_x[31], in_data.prev_x[30:0]});
         dy_u_ff  <= fadd_pre(in_data.cur_y, {~in_data.prev_y[31], in_data.prev_y[30:0]});
         dz_u_ff  <= fadd_pre(in_data.cur_z, {~in_data.prev_z[31], in_data.prev_z[30:0]});
         rd_u_ff  <= fadd_pre(in_data.cur_radius,
                              {~in_data.prev_radius[31], in_data.prev_radius[30:0]});
         dx_ff    <= round_pack(dx_u_ff);
         dy_ff    <= round_pack(dy_u_ff);
         dz_ff    <= round_pack(dz_u_ff);
         sx_u_ff  <= fmul_pre(dx_ff, dx_ff);
         sy_u_ff  <= fmul_pre(dy_ff, dy_ff);
         sz_u_ff  <= fmul_pre(dz_ff, dz_ff);
         sx_ff    <= round_pack(sx_u_ff);
         sy_ff    <= round_pack(sy_u_ff);
         sz_ff    <= round_pack(sz_u_ff);
         sxy_u_ff <= fadd_pre(sx_ff, sy_ff);
         sz5_ff   <= sz_ff;
         sxy_ff   <= round_pack(sxy_u_ff);
         sz6_ff   <= sz5_ff;
         sum_u_ff <= fadd_pre(sxy_ff, sz6_ff);
         sum_ff   <= round_pack(sum_u_ff);
      end
   end

   assign out_valid = valid_ff[7];
   assign out_meta  = meta_ff[7];
   assign out_sum   = sum_ff;

endmodule

[rtl/sfac_sqrt.sv]
// ----------------------------------------------------------------------------
// sfac_sqrt
// correctly rounded single-precision square root, two result bits per stage
// ----------------------------------------------------------------------------
module sfac_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  sfac_pkg::meta_type in_meta,
   input  logic [31:0]        in_val,
   output logic               out_valid,
   output sfac_pkg::meta_type out_meta,
   output logic [31:0]        out_root
);
   import sfac_pkg::*;

   logic          pre_valid_ff;
   meta_type      pre_meta_ff;
   sq_type        pre_ff;

   logic [SQ_STAGES-1:0] stg_valid_ff;
   meta_type             stg_meta_ff [0:SQ_STAGES-1];
   sq_type               stg_ff      [0:SQ_STAGES-1];
   sq_type               stg_in      [0:SQ_STAGES-1];

   logic          fin_valid_ff;
   meta_type      fin_meta_ff;
   logic [FW-1:0] fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
         stg_valid_ff <= '0;
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= in_valid;
         stg_valid_ff <= {stg_valid_ff[SQ_STAGES-2:0], pre_valid_ff};
         fin_valid_ff <= stg_valid_ff[SQ_STAGES-1];
      end
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
      always_comb begin
         sq_type cur;
         cur = (g == 0) ? pre_ff : stg_ff[(g == 0) ? 0 : g-1];
         for (int k = 0; k < SQ_PER_STAGE; k++) begin
            cur = sqrt_step(cur, g * SQ_PER_STAGE + k);
         end
         stg_in[g] = cur;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[g]      <= stg_in[g];
            stg_meta_ff[g] <= (g == 0) ? pre_meta_ff : stg_meta_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff      <= sqrt_pre(in_val);
         pre_meta_ff <= in_meta;
         fin_ff      <= sqrt_post(stg_ff[SQ_STAGES-1]);
         fin_meta_ff <= stg_meta_ff[SQ_STAGES-1];
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_meta  = fin_meta_ff;
   assign out_root  = fin_ff;

endmodule

[rtl/sfac_checker.sv]
// ----------------------------------------------------------------------------
// sfac_checker
// port-level checks of the anomaly check top level, bound to it below
// ----------------------------------------------------------------------------
module sfac_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sfac_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sfac_pkg::rsp_type rsp_payload
);
   import sfac_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed under stall");

   // a stalled request keeps its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request changed under stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.anomaly == ANOM_NONE || rsp_payload.anomaly == ANOM_BAD ||
                     rsp_payload.anomaly == ANOM_ZERO || rsp_payload.anomaly == ANOM_POS ||
                     rsp_payload.anomaly == ANOM_RAD))
      else $error("anomaly code out of range");

   // input only backs up when a result is held at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

bind sphere_frame_anomaly_check_top sfac_checker u_sfac_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[tb/sphere_frame_anomaly_check_top_tb.sv]
// ----------------------------------------------------------------------------
// sphere_frame_anomaly_check_top_tb
// streams sphere pairs through the anomaly check and compares each anomaly
// code and index against a single-precision model of the checks, over several
// threshold settings, with random idling on both channels
// ----------------------------------------------------------------------------
module sphere_frame_anomaly_check_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfac_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 40;
   localparam int PHASE_ITEMS = 117;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_POS_THR;
   logic [31:0] csr_wdata = '0;

   logic [31:0] pos_limit = THR_RESET;
   logic [31:0] rad_limit = THR_RESET;
   rsp_type     pending_codes[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   always #1 clock = ~clock;

   sphere_frame_anomaly_check_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // single bits to an exact real
   function automatic real bits_as_real(input logic [31:0] b);
      real v;
      if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
      if (b[30:23] == 8'd0) begin
         v = real'(b[22:0]) * (2.0 ** -149);
         return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0});
   endfunction

   // round a real to single bits, nearest even, with subnormals and overflow
   function automatic logic [31:0] real_as_bits(input real r);
      logic [63:0] d;
      logic [52:0] full, q, rest, half;
      int          ue, sh, base;
      logic [40:0] packed_v;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
         return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      ue   = int'(d[62:52]) - 1023;
      full = {1'b1, d[51:0]};
      sh   = (ue >= -126) ? 29 : 29 + (-126 - ue);
      if (sh > 53) return {d[63], 31'd0};
      q    = full >> sh;
      rest = full & ((53'd1 << sh) - 53'd1);
      half = 53'd1 << (sh - 1);
      if (rest > half || (rest == half && q[0])) q = q + 53'd1;
      base     = (ue >= -126) ? ue + 126 : 0;
      packed_v = (41'(base) << 23) + 41'(q);
      if (packed_v >= 41'h7F800000) return {d[63], 8'hFF, 23'd0};
      return {d[63], packed_v[30:0]};
   endfunction

   function automatic real single_op(input real r);
      return bits_as_real(real_as_bits(r));
   endfunction

   function automatic rsp_type anomaly_of(input req_type r, input logic [31:0] pthr,
                                          input logic [31:0] rthr);
      rsp_type     o;
      real         dx, dy, dz, sum, dpos;
      logic [31:0] drad;
      o.result_index = r.element_index;
      o.anomaly      = ANOM_NONE;
      if ((&r.cur_x[30:23]) || (&r.cur_y[30:23]) || (&r.cur_z[30:23]) ||
          (&r.cur_radius[30:23])) begin
         o.anomaly = ANOM_BAD;
      end else if (r.has_prev) begin
         if (r.cur_radius[30:0] == 0 && r.prev_radius[30:0] != 0) begin
            o.anomaly = ANOM_ZERO;
         end else begin
            dx   = single_op(bits_as_real(r.cur_x) - bits_as_real(r.prev_x));
            dy   = single_op(bits_as_real(r.cur_y) - bits_as_real(r.prev_y));
            dz   = single_op(bits_as_real(r.cur_z) - bits_as_real(r.prev_z));
            sum  = single_op(single_op(single_op(dx * dx) + single_op(dy * dy))
                             + single_op(dz * dz));
            dpos = single_op($sqrt(sum));
            drad = real_as_bits(bits_as_real(r.cur_radius) - bits_as_real(r.prev_radius));
            drad[31] = 1'b0;
            if (dpos > bits_as_real(pthr)) o.anomaly = ANOM_POS;
            else if (bits_as_real(drad) > bits_as_real(rthr)) o.anomaly = ANOM_RAD;
         end
      end
      return o;
   endfunction

   function automatic req_type sphere_pair(input logic [31:0] px, py, pz, pr,
                                           input logic [31:0] cx, cy, cz, cr,
                                           input logic hp, input logic [15:0] idx);
      req_type r;
      r.prev_x = px; r.prev_y = py; r.prev_z = pz; r.prev_radius = pr;
      r.cur_x = cx; r.cur_y = cy; r.cur_z = cz; r.cur_radius = cr;
      r.has_prev = hp; r.element_index = idx;
      return r;
   endfunction

   // moderate float with random sign
   function automatic logic [31:0] plain_float();
      return {1'($urandom_range(0, 1)), 8'($urandom_range(122, 132)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] odd_float();
      case ($urandom_range(0, 5))
         0: return {1'($urandom), 8'hFF, 23'($urandom)};
         1: return {1'($urandom), 8'hFF, 23'd0};
         2: return {1'($urandom), 31'd0};
         3: return {1'($urandom), 8'd0, 23'($urandom)};
         4: return {1'($urandom), 8'hFE, 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // current value derived from the previous one, or a fresh moderate float
   function automatic logic [31:0] drift(input logic [31:0] p);
      case ($urandom_range(0, 3))
         0: return p;
         1: return p ^ 32'($urandom_range(0, 1023));
         2: return {p[31], p[30:23] + 8'($urandom_range(0, 2)), 23'($urandom)};
         default: return plain_float();
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int      k;
      if ($urandom_range(0, 9) < 2) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 1'($urandom), 16'($urandom)};
         return r;
      end
      r = sphere_pair(plain_float(), plain_float(), plain_float(),
                      plain_float() & 32'h7FFFFFFF,
                      32'd0, 32'd0, 32'd0, 32'd0, $urandom_range(0, 7) != 0, 16'($urandom));
      r.cur_x = drift(r.prev_x);
      r.cur_y = drift(r.prev_y);
      r.cur_z = drift(r.prev_z);
      r.cur_radius = ($urandom_range(0, 9) == 0) ? {1'($urandom), 31'd0}
                                                  : drift(r.prev_radius);
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(0, 7);
         case (k)
            0: r.prev_x = odd_float();
            1: r.prev_y = odd_float();
            2: r.prev_z = odd_float();
            3: r.prev_radius = odd_float();
            4: r.cur_x = odd_float();
            5: r.cur_y = odd_float();
            6: r.cur_z = odd_float();
            default: r.cur_radius = odd_float();
         endcase
      end
      return r;
   endfunction

   task automatic send_pair(input req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      pending_codes.push_back(anomaly_of(r, pos_limit, rad_limit));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_thresholds(input logic [31:0] pthr, input logic [31:0] rthr);
      csr_write <= 1'b1; csr_index <= CSR_POS_THR; csr_wdata <= pthr;
      @(negedge clock);
      csr_index <= CSR_RAD_THR; csr_wdata <= rthr;
      @(negedge clock);
      csr_write <= 1'b0;
      pos_limit = pthr;
      rad_limit = rthr;
   endtask

   // random stall bursts on the result side
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %p", rsp_payload);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_payload.anomaly !== want.anomaly ||
                rsp_payload.result_index !== want.result_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("index %h: expected code %0d index %h, got code %0d index %h",
                           want.result_index, want.anomaly, want.result_index,
                           rsp_payload.anomaly, rsp_payload.result_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("sphere_frame_anomaly_check_top_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   typedef struct {
      req_type    pair;
      bit         typed;
      logic [2:0] code;
   } directed_row;

   directed_row rows[$];
   logic [31:0] phase_pos[6] = '{32'h0, 32'h7F800000, 32'h7FC00000, 32'h7F7FFFFF,
                                 32'h0, 32'h40A00000};
   logic [31:0] phase_rad[6] = '{32'h0, 32'h7F800000, 32'hFFC00000, 32'h00000001,
                                 32'h0, 32'h40A00000};

   initial begin
      rsp_type want;
      rows.push_back('{sphere_pair(0, 0, 0, 0, 32'h7FC00000, 0, 0, 0, 1'b0, 16'h0000),
                       1'b1, ANOM_BAD});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 0, 0, 0, 32'h7F800000, 1'b1, 16'h0001),
                       1'b1, ANOM_BAD});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 0, 32'hFF800000, 0, 0, 1'b1, 16'h0002),
                       1'b1, ANOM_BAD});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 1'b1, 16'h0003),
                       1'b1, ANOM_BAD});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF),
                       1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 32'h7F7FFFFF, 0, 0, 32'h7F7FFFFF, 1'b0,
                                   16'h8000), 1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(0, 0, 0, 32'h3F800000, 0, 0, 0, 0, 1'b1, 16'h0006),
                       1'b1, ANOM_ZERO});
      rows.push_back('{sphere_pair(0, 0, 0, 32'h3F800000, 0, 0, 0, 32'h80000000, 1'b1,
                                   16'h0007), 1'b1, ANOM_ZERO});
      // nan previous radius counts as not zero
      rows.push_back('{sphere_pair(0, 0, 0, 32'h7FC00000, 0, 0, 0, 0, 1'b1, 16'h0008),
                       1'b1, ANOM_ZERO});
      rows.push_back('{sphere_pair(0, 0, 0, 32'h80000000, 0, 0, 0, 0, 1'b1, 16'h0009),
                       1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 32'h40C00000, 0, 0, 0, 1'b1, 16'h000A),
                       1'b1, ANOM_POS});
      rows.push_back('{sphere_pair(0, 0, 0, 0, 0, 32'h40A00000, 0, 0, 1'b1, 16'h000B),
                       1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(0, 0, 0, 32'h3F800000, 0, 0, 0, 32'h40E00000, 1'b1,
                                   16'h000C), 1'b1, ANOM_RAD});
      rows.push_back('{sphere_pair(32'h7FC00000, 0, 0, 0, 0, 0, 0, 0, 1'b1, 16'h000D),
                       1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(0, 0, 32'h7F800000, 0, 0, 0, 0, 0, 1'b1, 16'h000E),
                       1'b1, ANOM_POS});
      rows.push_back('{sphere_pair(32'hFF7FFFFF, 0, 0, 0, 32'h7F7FFFFF, 0, 0, 0, 1'b1,
                                   16'h000F), 1'b1, ANOM_POS});
      rows.push_back('{sphere_pair(0, 0, 0, 32'h7F800000, 0, 0, 0, 32'h3F800000, 1'b1,
                                   16'h0010), 1'b1, ANOM_RAD});
      rows.push_back('{sphere_pair(32'h00000001, 0, 0, 0, 32'h80000001, 0, 0, 0, 1'b1,
                                   16'h0011), 1'b1, ANOM_NONE});
      rows.push_back('{sphere_pair(32'h40400000, 32'h40800000, 0, 0, 0, 0, 0, 0, 1'b1,
                                   16'h0012), 1'b0, ANOM_NONE});
      rows.push_back('{sphere_pair(32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h40000000,
                                   32'h40600000, 32'h40600000, 32'h40600000, 32'h40000000,
                                   1'b1, 16'h0013), 1'b0, ANOM_NONE});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_pair(rows[i].pair);
         if (rows[i].typed) begin
            want = pending_codes.pop_back();
            want.anomaly = rows[i].code;
            pending_codes.push_back(want);
         end
      end

      for (int p = 0; p < 6; p++) begin
         drain();
         if (p == 4) write_thresholds({1'b0, 8'($urandom_range(124, 131)), 23'($urandom)},
                                      {1'b0, 8'($urandom_range(124, 131)), 23'($urandom)});
         else write_thresholds(phase_pos[p], phase_rad[p]);
         quiet = (p == 5);
         repeat (PHASE_ITEMS) send_pair(random_pair());
      end
      drain();

      if (mismatches == 0) $display("sphere_frame_anomaly_check_top_tb: clean");
      else $display("sphere_frame_anomaly_check_top_tb: errors");
      $finish;
   end

endmodule

[filelist.f]
rtl/sfac_pkg.sv
rtl/sfac_front.sv
rtl/sfac_sqrt.sv
rtl/sphere_frame_anomaly_check_top.sv
rtl/sfac_checker.sv
tb/sphere_frame_anomaly_check_top_tb.sv
